/* rtl/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and the CRC-4 function of the packet deframer
// Result record, byte kind and status codes, and the CRC-4 byte update.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NameLenW = 4;
  localparam int unsigned MsgLenW  = 5;
  localparam int unsigned CrcW     = 4;
  localparam int unsigned HiKeepW  = NameLenW + 1;

  localparam logic [2:0]      FlagOk      = 3'b101;
  localparam logic [CrcW-1:0] CrcPolyRefl = 4'hC;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_NAME = 2'd1,
    KIND_MSG  = 2'd2,
    KIND_SKIP = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_FLAG = 2'd1,
    ST_BAD_CRC  = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0]    out_byte;
    kind_e               kind;
    logic [NameLenW-1:0] name_len;
    logic [MsgLenW-1:0]  msg_len;
    logic                pend;
    status_e             status;
  } mpd_res_t;

  // Reflected CRC-4/ITU update over one byte, bit by bit.
  function automatic logic [CrcW-1:0] crc4_byte(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = b ^ {{(ByteW-CrcW){1'b0}}, crc};
    for (int i = 0; i < ByteW; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ {{(ByteW-CrcW){1'b0}}, CrcPolyRefl};
      end else begin
        v = v >> 1;
      end
    end
    return v[CrcW-1:0];
  endfunction

endpackage

/* rtl/mpd_core.sv */
// ----------------------------------------------------------------------------
// mpd_core: header parse, length tracking and CRC check
// Holds the per-packet state and forms the result of the byte being taken.
// ----------------------------------------------------------------------------
module mpd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [mpd_pkg::ByteW-1:0]     byte_i,
  input  logic                          last_i,
  output mpd_pkg::mpd_res_t             res_o
);
  import mpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HDR0,
    PH_HDR1,
    PH_NAME,
    PH_MSG
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [HiKeepW-1:0]  hi_q, hi_d;
  logic [NameLenW-1:0] name_left_q, name_left_d;
  logic [MsgLenW-1:0]  msg_left_q, msg_left_d;
  logic [CrcW-1:0]     crc_q, crc_d;
  logic [CrcW-1:0]     rx_crc_q, rx_crc_d;
  logic                skip_q, skip_d;
  logic [NameLenW-1:0] held_nl_q, held_nl_d;
  logic [MsgLenW-1:0]  held_ml_q, held_ml_d;
  logic                done;
  logic [NameLenW-1:0] name_dec;
  logic [MsgLenW-1:0]  msg_dec;

  assign name_dec = name_left_q - 1'b1;
  assign msg_dec  = msg_left_q - 1'b1;

  always_comb begin
    phase_d     = phase_q;
    hi_d        = hi_q;
    name_left_d = name_left_q;
    msg_left_d  = msg_left_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    skip_d      = skip_q;
    held_nl_d   = held_nl_q;
    held_ml_d   = held_ml_q;
    done        = 1'b0;

    res_o.out_byte = byte_i;
    res_o.kind     = KIND_HDR;
    res_o.name_len = '0;
    res_o.msg_len  = '0;
    res_o.pend     = 1'b0;
    res_o.status   = ST_OK;

    if (skip_q) begin
      res_o.kind = KIND_SKIP;
      if (last_i) begin
        skip_d  = 1'b0;
        phase_d = PH_HDR0;
      end
    end else if (phase_q == PH_HDR0) begin
      hi_d  = byte_i[HiKeepW-1:0];
      crc_d = crc4_byte('0, byte_i);
      if (byte_i[7:5] != FlagOk) begin
        res_o.status = ST_BAD_FLAG;
        phase_d      = PH_HDR0;
        skip_d       = !last_i;
      end else if (last_i) begin
        res_o.status = ST_TRUNC;
        phase_d      = PH_HDR0;
      end else begin
        phase_d = PH_HDR1;
      end
    end else begin
      unique case (phase_q)
        PH_HDR1: begin
          res_o.kind  = KIND_HDR;
          held_nl_d   = hi_q[HiKeepW-1:1];
          held_ml_d   = {hi_q[0], byte_i[7:4]};
          rx_crc_d    = byte_i[CrcW-1:0];
          crc_d       = crc4_byte(crc_q, {byte_i[7:4], 4'h0});
          name_left_d = held_nl_d;
          msg_left_d  = held_ml_d;
          if (held_nl_d != '0) begin
            phase_d = PH_NAME;
          end else if (held_ml_d != '0) begin
            phase_d = PH_MSG;
          end else begin
            done = 1'b1;
          end
        end
        PH_NAME: begin
          res_o.kind  = KIND_NAME;
          crc_d       = crc4_byte(crc_q, byte_i);
          name_left_d = name_dec;
          if (name_dec == '0) begin
            if (msg_left_q != '0) begin
              phase_d = PH_MSG;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_MSG: begin
          res_o.kind = KIND_MSG;
          crc_d      = crc4_byte(crc_q, byte_i);
          msg_left_d = msg_dec;
          if (msg_dec == '0) begin
            done = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      res_o.name_len = held_nl_d;
      res_o.msg_len  = held_ml_d;
      if (done) begin
        res_o.pend = 1'b1;
        phase_d    = PH_HDR0;
        if (crc_d != rx_crc_d) begin
          res_o.status = ST_BAD_CRC;
          skip_d       = !last_i;
        end
      end else if (last_i) begin
        // The buffer ran out before the packet did; drop the partial packet.
        res_o.status = ST_TRUNC;
        phase_d      = PH_HDR0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR0;
      hi_q        <= '0;
      name_left_q <= '0;
      msg_left_q  <= '0;
      crc_q       <= '0;
      rx_crc_q    <= '0;
      skip_q      <= 1'b0;
      held_nl_q   <= '0;
      held_ml_q   <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      hi_q        <= hi_d;
      name_left_q <= name_left_d;
      msg_left_q  <= msg_left_d;
      crc_q       <= crc_d;
      rx_crc_q    <= rx_crc_d;
      skip_q      <= skip_d;
      held_nl_q   <= held_nl_d;
      held_ml_q   <= held_ml_d;
    end
  end

  a_skip_waits_hdr0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> phase_q == PH_HDR0)
    else $error("discard mode entered outside the header wait");

  a_name_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_NAME |-> name_left_q != '0)
    else $error("name phase with no name bytes left");

  a_msg_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MSG |-> msg_left_q != '0)
    else $error("message phase with no message bytes left");

  a_crc_err_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_o.status == ST_BAD_CRC) |-> res_o.pend)
    else $error("CRC mismatch reported away from a packet end");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_o.kind == KIND_SKIP) |-> (res_o.status == ST_OK && !res_o.pend))
    else $error("discarded byte carries status or packet end");

endmodule

/* rtl/mpd_out_reg.sv */
// ----------------------------------------------------------------------------
// mpd_out_reg: result register of the deframer
// Holds one result and takes the next one in the cycle the current one leaves.
// ----------------------------------------------------------------------------
module mpd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mpd_pkg::mpd_res_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              take_i,
  output mpd_pkg::mpd_res_t res_o
);
  import mpd_pkg::*;

  logic     valid_q;
  mpd_res_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= res_i;
    end
  end

endmodule

/* rtl/message_packet_deframer_crc4.sv */
// ----------------------------------------------------------------------------
// message_packet_deframer_crc4: length-prefixed packet deframer with CRC-4
// Splits a byte stream into header, name and message bytes, marks discarded
// bytes as skipped and checks the CRC-4/ITU of each packet.
//
//   Channel   Dir  Fields
//   s_axis    in   tdata = data_byte, tlast = buffer_last
//   m_axis    out  tdata = out_byte, name_length, message_length, status
//                  tuser = byte_kind, tlast = packet_end
//
// One byte per cycle is taken while the result register is free or emptied;
// its result appears in the cycle after the transfer. The per-byte parse and
// the unrolled CRC byte update sit between the state and result registers.
// Reset clears the parse state; the block then waits for a first header byte.
// A stall on m_axis holds one result; s_axis keeps flowing when it is taken.
// ----------------------------------------------------------------------------
module message_packet_deframer_crc4 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [11:8] name_length,
                                      // [16:12] message_length, [18:17] status
  output logic [1:0]  m_axis_tuser,   // [1:0] byte_kind
  output logic        m_axis_tlast
);
  import mpd_pkg::*;

  logic     accept;
  logic     out_ready;
  mpd_res_t core_res;
  mpd_res_t out_res;

  assign s_axis_tready = out_ready;
  assign accept        = s_axis_tvalid && out_ready;

  mpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .res_o    (core_res)
  );

  mpd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s_axis_tvalid),
    .res_i   (core_res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.status, out_res.msg_len,
                         out_res.name_len, out_res.out_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.pend;

endmodule
